// ----- sv/lstc_pkg.sv -----
// ----------------------------------------------------------------------------
// lstc_pkg
// Types and constants shared by the lidar slope terrain classifier.
// ----------------------------------------------------------------------------
package lstc_pkg;

	// one lidar point, input transaction
	typedef struct packed {
		logic signed [19:0] x_mm;
		logic signed [19:0] y_mm;
		logic signed [19:0] z_mm;
		logic        [17:0] range_mm;
		logic               slice_start;
	} lstc_point_t;

	// one cell mark, output transaction
	typedef struct packed {
		logic [9:0] cell_x;
		logic [9:0] cell_y;
		logic       obstacle;
		logic       slammable;
	} lstc_mark_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DIVX,
		S_DIVY,
		S_MUL,
		S_DONE
	} lstc_state_t;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_OBS_TAN2   = 3'd0;
	localparam logic [2:0] REG_SLAM_TAN2  = 3'd1;
	localparam logic [2:0] REG_MIN_HEIGHT = 3'd2;
	localparam logic [2:0] REG_MAX_OBS_H  = 3'd3;
	localparam logic [2:0] REG_DROP       = 3'd4;
	localparam logic [2:0] REG_ORIGIN_X   = 3'd5;
	localparam logic [2:0] REG_ORIGIN_Y   = 3'd6;
	localparam logic [2:0] REG_CELL_SIZE  = 3'd7;

	// register reset values
	localparam logic        [23:0] OBS_TAN2_RST   = 24'd8684;
	localparam logic        [23:0] SLAM_TAN2_RST  = 24'd2107860;
	localparam logic signed [19:0] MIN_HEIGHT_RST = -20'sd500;
	localparam logic signed [19:0] MAX_OBS_H_RST  = 20'sd1500;
	localparam logic        [15:0] DROP_RST       = 16'd100;
	localparam logic        [9:0]  CELL_SIZE_RST  = 10'd50;

	// ranges at or below this are no-returns
	localparam logic [17:0] NULL_RANGE_MM = 18'd200;

	// multiplier sequence: number of steps
	localparam int MUL_STEPS = 8;

endpackage

// ----- sv/lidar_slope_terrain_classifier_top.sv -----
// ----------------------------------------------------------------------------
// lidar_slope_terrain_classifier_top
// Classifies consecutive lidar point pairs of a slice by slope and drop and
// emits the map cell of the earlier point with obstacle / slammable flags.
// ----------------------------------------------------------------------------
//
//  channel  | signals                         | direction | carries
//  ---------+---------------------------------+-----------+---------------------
//  point    | point_valid, point_stall, point | in        | lstc_point_t
//  mark     | mark_valid, mark_stall, mark    | out       | lstc_mark_t
//  config   | psel .. pready, paddr[4:0]      | in/out    | 8 regs, 32 bit
//
// Sequence: a point that forms a pair runs two CW-step restoring divisions for the
//   cell index, CW = clog2(MAP_CELLS), on a shared subtractor, then eight steps on
//   one 24x21 multiplier.
// A point that forms no pair (slice start, short range, low, off grid) leaves the sequencer idle.
// point_stall is high while the sequencer works on a point.
// A finished mark sits in an output register; the next point is taken while it
//   waits, and the sequencer holds in S_DONE only while that register is full and stalled.
// Reset is asynchronous; it restores register defaults and forgets the previous point.
// ----------------------------------------------------------------------------
module lidar_slope_terrain_classifier_top #(
	parameter int MAP_CELLS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// point transactions
	input  logic                 point_valid,
	output logic                 point_stall,
	input  lstc_pkg::lstc_point_t point,
	// mark transactions
	output logic                 mark_valid,
	input  logic                 mark_stall,
	output lstc_pkg::lstc_mark_t  mark,
	// register port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	// quotient width: cell index is below MAP_CELLS
	localparam int CW   = $clog2(MAP_CELLS);
	localparam int CBW  = $clog2(CW);
	localparam int CNTW = (CBW > 3) ? CBW : 3;
	// compare / divide width: covers 20-bit offsets and MAP_CELLS * cell size
	localparam int CMPW = (CW + 11 > 20) ? CW + 11 : 20;
	localparam int ACCW = 65;

	// ---------------- configuration registers ----------------
	logic        [23:0] obs_tan2_q;
	logic        [23:0] slam_tan2_q;
	logic signed [19:0] min_h_q;
	logic signed [19:0] max_obs_h_q;
	logic        [15:0] drop_thr_q;
	logic signed [19:0] origin_x_q;
	logic signed [19:0] origin_y_q;
	logic        [9:0]  cell_size_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obs_tan2_q  <= lstc_pkg::OBS_TAN2_RST;
			slam_tan2_q <= lstc_pkg::SLAM_TAN2_RST;
			min_h_q     <= lstc_pkg::MIN_HEIGHT_RST;
			max_obs_h_q <= lstc_pkg::MAX_OBS_H_RST;
			drop_thr_q  <= lstc_pkg::DROP_RST;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			cell_size_q <= lstc_pkg::CELL_SIZE_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				lstc_pkg::REG_OBS_TAN2:   obs_tan2_q  <= pwdata[23:0];
				lstc_pkg::REG_SLAM_TAN2:  slam_tan2_q <= pwdata[23:0];
				lstc_pkg::REG_MIN_HEIGHT: min_h_q     <= pwdata[19:0];
				lstc_pkg::REG_MAX_OBS_H:  max_obs_h_q <= pwdata[19:0];
				lstc_pkg::REG_DROP:       drop_thr_q  <= pwdata[15:0];
				lstc_pkg::REG_ORIGIN_X:   origin_x_q  <= pwdata[19:0];
				lstc_pkg::REG_ORIGIN_Y:   origin_y_q  <= pwdata[19:0];
				lstc_pkg::REG_CELL_SIZE:  cell_size_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			lstc_pkg::REG_OBS_TAN2:   prdata = 32'(obs_tan2_q);
			lstc_pkg::REG_SLAM_TAN2:  prdata = 32'(slam_tan2_q);
			lstc_pkg::REG_MIN_HEIGHT: prdata = 32'(min_h_q);
			lstc_pkg::REG_MAX_OBS_H:  prdata = 32'(max_obs_h_q);
			lstc_pkg::REG_DROP:       prdata = 32'(drop_thr_q);
			lstc_pkg::REG_ORIGIN_X:   prdata = 32'(origin_x_q);
			lstc_pkg::REG_ORIGIN_Y:   prdata = 32'(origin_y_q);
			lstc_pkg::REG_CELL_SIZE:  prdata = 32'(cell_size_q);
			default:                  prdata = '0;
		endcase
	end

	// zero cell size acts as 1 mm
	logic [9:0] cs_eff;
	assign cs_eff = (cell_size_q == '0) ? 10'd1 : cell_size_q;

	// offsets at or above this leave the grid
	logic [CMPW-1:0] grid_lim;
	assign grid_lim = CMPW'(MAP_CELLS) * CMPW'(cs_eff);

	// ---------------- state ----------------
	lstc_pkg::lstc_state_t state_q, state_d;
	logic [CNTW-1:0]       cnt_q;
	logic                  prev_valid_q;
	logic                  mark_valid_q;

	logic signed [19:0] prev_x_q, prev_y_q, prev_z_q;
	logic        [17:0] prev_range_q;

	// pair working registers
	logic [19:0]      ax_q, ay_q, az_q;   // |dx|, |dy|, |dz|
	logic             drop_q;             // dz below -drop threshold
	logic             zok_q;              // later z at or below obstacle height
	logic [19:0]      rem_q;              // divider remainder
	logic [19:0]      diffy_q;            // y offset waiting for the divider
	logic [CW-1:0]    quo_q;
	logic [CW-1:0]    cx_q;
	logic [44:0]      prod_q;
	logic [40:0]      xy2_q;
	logic [39:0]      dz2_q;
	logic [ACCW-1:0]  acc_q;
	logic             steep_obs_q;
	lstc_pkg::lstc_mark_t mark_q;

	// ---------------- accept-time checks ----------------
	logic              accept;
	logic signed [20:0] dx, dy, dz, offx, offy;
	logic        [21:0] drop_sum;
	logic              x_on_grid, y_on_grid, pair_go;

	assign dx   = 21'(point.x_mm) - 21'(prev_x_q);
	assign dy   = 21'(point.y_mm) - 21'(prev_y_q);
	assign dz   = 21'(point.z_mm) - 21'(prev_z_q);
	assign offx = 21'(prev_x_q) - 21'(origin_x_q);
	assign offy = 21'(prev_y_q) - 21'(origin_y_q);
	// dz + drop < 0  <=>  dz < -drop
	assign drop_sum = 22'(dz) + 22'(drop_thr_q);

	assign x_on_grid = !offx[20] && (CMPW'(offx[19:0]) < grid_lim);
	assign y_on_grid = !offy[20] && (CMPW'(offy[19:0]) < grid_lim);

	assign pair_go = !point.slice_start && prev_valid_q
		&& (prev_range_q > lstc_pkg::NULL_RANGE_MM)
		&& (point.range_mm > lstc_pkg::NULL_RANGE_MM)
		&& (point.z_mm >= min_h_q) && x_on_grid && y_on_grid;

	// ---------------- shared subtractor (restoring division) ----------------
	logic [CMPW:0]   trial;
	logic            div_ge;
	logic [CW-1:0]   quo_next;
	assign trial    = {1'b0, CMPW'(rem_q)} - {1'b0, CMPW'(cs_eff) << cnt_q};
	assign div_ge   = !trial[CMPW];
	assign quo_next = {quo_q[CW-2:0], div_ge};

	// ---------------- shared multiplier ----------------
	logic [23:0] mul_a;
	logic [20:0] mul_b;
	logic [44:0] mul_p;

	always_comb begin
		case (cnt_q)
			CNTW'(0): begin mul_a = 24'(ax_q);  mul_b = 21'(ax_q); end
			CNTW'(1): begin mul_a = 24'(ay_q);  mul_b = 21'(ay_q); end
			CNTW'(2): begin mul_a = 24'(az_q);  mul_b = 21'(az_q); end
			CNTW'(3): begin mul_a = obs_tan2_q;  mul_b = xy2_q[20:0]; end
			CNTW'(4): begin mul_a = obs_tan2_q;  mul_b = 21'(xy2_q[40:21]); end
			CNTW'(5): begin mul_a = slam_tan2_q; mul_b = xy2_q[20:0]; end
			CNTW'(6): begin mul_a = slam_tan2_q; mul_b = 21'(xy2_q[40:21]); end
			default:  begin mul_a = '0;          mul_b = '0; end
		endcase
	end
	assign mul_p = 45'(mul_a) * 45'(mul_b);

	// dz^2 * 2^16, compared against threshold * xy^2
	logic [ACCW-1:0] lhs;
	logic [ACCW-1:0] acc_add;
	logic            hazard;
	assign lhs     = ACCW'({dz2_q, 16'b0});
	assign acc_add = acc_q + (ACCW'(prod_q) << 21);
	assign hazard  = steep_obs_q || drop_q;

	// ---------------- sequencer ----------------
	logic out_free, load_mark;
	assign out_free = !mark_valid_q || !mark_stall;

	always_comb begin
		state_d     = state_q;
		point_stall = 1'b1;
		load_mark   = 1'b0;
		case (state_q)
			lstc_pkg::S_IDLE: begin
				point_stall = 1'b0;
				if (point_valid && pair_go)
					state_d = lstc_pkg::S_DIVX;
			end
			lstc_pkg::S_DIVX: begin
				if (cnt_q == '0)
					state_d = lstc_pkg::S_DIVY;
			end
			lstc_pkg::S_DIVY: begin
				if (cnt_q == '0)
					state_d = lstc_pkg::S_MUL;
			end
			lstc_pkg::S_MUL: begin
				if (cnt_q == CNTW'(lstc_pkg::MUL_STEPS - 1))
					state_d = lstc_pkg::S_DONE;
			end
			lstc_pkg::S_DONE: begin
				if (out_free) begin
					load_mark = 1'b1;
					state_d   = lstc_pkg::S_IDLE;
				end
			end
			default: state_d = lstc_pkg::S_IDLE;
		endcase
	end

	assign accept = point_valid && !point_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lstc_pkg::S_IDLE;
			cnt_q        <= '0;
			prev_valid_q <= 1'b0;
			mark_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				prev_valid_q <= 1'b1;
			if (load_mark)
				mark_valid_q <= 1'b1;
			else if (!mark_stall)
				mark_valid_q <= 1'b0;
			case (state_q)
				lstc_pkg::S_IDLE: cnt_q <= CNTW'(CW - 1);
				lstc_pkg::S_DIVX: cnt_q <= (cnt_q == '0) ? CNTW'(CW - 1) : cnt_q - 1'b1;
				lstc_pkg::S_DIVY: cnt_q <= (cnt_q == '0) ? '0 : cnt_q - 1'b1;
				lstc_pkg::S_MUL:  cnt_q <= cnt_q + 1'b1;
				default:          cnt_q <= cnt_q;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_x_q     <= point.x_mm;
			prev_y_q     <= point.y_mm;
			prev_z_q     <= point.z_mm;
			prev_range_q <= point.range_mm;
			ax_q    <= dx[20] ? 20'(-dx) : dx[19:0];
			ay_q    <= dy[20] ? 20'(-dy) : dy[19:0];
			az_q    <= dz[20] ? 20'(-dz) : dz[19:0];
			drop_q  <= drop_sum[21];
			zok_q   <= point.z_mm <= max_obs_h_q;
			rem_q   <= offx[19:0];
			diffy_q <= offy[19:0];
		end

		case (state_q)
			lstc_pkg::S_DIVX: begin
				quo_q <= quo_next;
				if (cnt_q == '0) begin
					cx_q  <= quo_next;
					rem_q <= diffy_q;
				end else if (div_ge) begin
					rem_q <= trial[19:0];
				end
			end
			lstc_pkg::S_DIVY: begin
				quo_q <= quo_next;
				if (div_ge)
					rem_q <= trial[19:0];
			end
			lstc_pkg::S_MUL: begin
				prod_q <= mul_p;
				case (cnt_q)
					CNTW'(1): xy2_q <= 41'(prod_q);
					CNTW'(2): xy2_q <= xy2_q + 41'(prod_q);
					CNTW'(3): dz2_q <= prod_q[39:0];
					CNTW'(4): acc_q <= ACCW'(prod_q);
					CNTW'(5): acc_q <= acc_add;
					CNTW'(6): begin
						steep_obs_q <= acc_q < lhs;
						acc_q       <= ACCW'(prod_q);
					end
					CNTW'(7): acc_q <= acc_add;
					default: ;
				endcase
			end
			default: ;
		endcase

		if (load_mark) begin
			mark_q.cell_x    <= 10'(cx_q);
			mark_q.cell_y    <= 10'(quo_q);
			mark_q.obstacle  <= hazard && zok_q;
			mark_q.slammable <= hazard && (acc_q < lhs);
		end
	end

	assign mark_valid = mark_valid_q;
	assign mark       = mark_q;

	// ---------------- assertions ----------------
	// a mark is only produced from the final sequencer state
	a_mark_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mark_valid_q) |-> $past(state_q) == lstc_pkg::S_DONE)
		else $error("mark raised outside S_DONE");

	// the y division ends with a remainder below the cell size
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lstc_pkg::S_MUL && $past(state_q) == lstc_pkg::S_DIVY)
		|-> rem_q < 20'(cs_eff))
		else $error("divider remainder not below cell size");

	// slammable is only reported for a hazard
	a_slam_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mark_valid_q) && mark_q.slammable |-> $past(steep_obs_q || drop_q))
		else $error("slammable without hazard");

	// multiplier step count stays inside its sequence
	a_mul_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lstc_pkg::S_MUL |-> cnt_q <= CNTW'(lstc_pkg::MUL_STEPS - 1))
		else $error("multiplier step out of range");

endmodule

// ----- dv/tb_lidar_slope_terrain_classifier_top.sv -----
// ----------------------------------------------------------------------------
// tb_lidar_slope_terrain_classifier_top
// Self-checking bench for the slope terrain classifier. Points are pushed in
// as whole slices with controlled slopes, drops, heights and ranges, mixed
// with raw random points. A scoreboard predicts the cell mark of every pair
// that survives the skip rules and checks each mark as it leaves the block.
// The run steps through several register settings and idling patterns. One
// phase holds the mark side off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_lidar_slope_terrain_classifier_top;

	localparam int MAP_CELLS     = 1024;
	// settle well past the slowest pair before a register write
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES   = 400;
	localparam int ITEMS_PER_RUN = 110;

	// ------------------------------------------------------------------------
	// Scoreboard: own copy of registers and previous point, queue of marks due
	// ------------------------------------------------------------------------
	class mark_predictor;
		logic        [23:0] obs_t2;
		logic        [23:0] slam_t2;
		logic signed [19:0] min_h;
		logic signed [19:0] max_obs;
		logic        [15:0] drop;
		logic signed [19:0] org_x;
		logic signed [19:0] org_y;
		logic        [9:0]  cell_sz;

		logic signed [19:0] prev_x;
		logic signed [19:0] prev_y;
		logic signed [19:0] prev_z;
		logic        [17:0] prev_r;
		bit                 prev_ok;

		lstc_pkg::lstc_mark_t marks_due[$];
		int         n_fail;

		function new();
			obs_t2  = lstc_pkg::OBS_TAN2_RST;
			slam_t2 = lstc_pkg::SLAM_TAN2_RST;
			min_h   = lstc_pkg::MIN_HEIGHT_RST;
			max_obs = lstc_pkg::MAX_OBS_H_RST;
			drop    = lstc_pkg::DROP_RST;
			org_x   = '0;
			org_y   = '0;
			cell_sz = lstc_pkg::CELL_SIZE_RST;
			prev_x  = '0;
			prev_y  = '0;
			prev_z  = '0;
			prev_r  = '0;
			prev_ok = 1'b0;
			n_fail  = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				lstc_pkg::REG_OBS_TAN2:   obs_t2  = val[23:0];
				lstc_pkg::REG_SLAM_TAN2:  slam_t2 = val[23:0];
				lstc_pkg::REG_MIN_HEIGHT: min_h   = val[19:0];
				lstc_pkg::REG_MAX_OBS_H:  max_obs = val[19:0];
				lstc_pkg::REG_DROP:       drop    = val[15:0];
				lstc_pkg::REG_ORIGIN_X:   org_x   = val[19:0];
				lstc_pkg::REG_ORIGIN_Y:   org_y   = val[19:0];
				lstc_pkg::REG_CELL_SIZE:  cell_sz = val[9:0];
				default: ;
			endcase
		endfunction

		// dz2 * 2^16 > t * xy2, without overflow
		function bit is_steeper(logic [63:0] dz2, logic [63:0] xy2, logic [23:0] t);
			logic [63:0] lhs;
			lhs = dz2 << 16;
			if (lhs == 0)
				return 1'b0;
			if (xy2 == 0)
				return 1'b1;
			return 64'(t) <= (lhs - 1) / xy2;
		endfunction

		// grid index of a coordinate, -1 when off the grid
		function longint cell_index(logic signed [19:0] c, logic signed [19:0] o);
			longint diff;
			longint cs;
			longint idx;
			diff = longint'(c) - longint'(o);
			cs   = (cell_sz == 0) ? 1 : longint'(cell_sz);
			if (diff < 0)
				return -1;
			idx = diff / cs;
			if (idx >= MAP_CELLS)
				return -1;
			return idx;
		endfunction

		function void note_point(lstc_pkg::lstc_point_t p);
			longint      cx;
			longint      cy;
			longint      dx;
			longint      dy;
			longint      dz;
			logic [63:0] xy2;
			logic [63:0] dz2;
			lstc_pkg::lstc_mark_t m;
			if (!p.slice_start && prev_ok && prev_r > lstc_pkg::NULL_RANGE_MM &&
					p.range_mm > lstc_pkg::NULL_RANGE_MM && p.z_mm >= min_h) begin
				cx = cell_index(prev_x, org_x);
				cy = cell_index(prev_y, org_y);
				if (cx >= 0 && cy >= 0) begin
					dx  = longint'(p.x_mm) - longint'(prev_x);
					dy  = longint'(p.y_mm) - longint'(prev_y);
					dz  = longint'(p.z_mm) - longint'(prev_z);
					xy2 = 64'(dx * dx + dy * dy);
					dz2 = 64'(dz * dz);
					m.cell_x    = cx[9:0];
					m.cell_y    = cy[9:0];
					m.obstacle  = 1'b0;
					m.slammable = 1'b0;
					if (is_steeper(dz2, xy2, obs_t2) || dz < -longint'(drop)) begin
						m.obstacle  = (p.z_mm <= max_obs);
						m.slammable = is_steeper(dz2, xy2, slam_t2);
					end
					marks_due.push_back(m);
				end
			end
			prev_x  = p.x_mm;
			prev_y  = p.y_mm;
			prev_z  = p.z_mm;
			prev_r  = p.range_mm;
			prev_ok = 1'b1;
		endfunction

		function void check_mark(lstc_pkg::lstc_mark_t got);
			lstc_pkg::lstc_mark_t want;
			if (marks_due.size() == 0) begin
				n_fail++;
				if (n_fail <= 10)
					$display("unexpected mark: cell (%0d,%0d) obs %0b slam %0b",
						got.cell_x, got.cell_y, got.obstacle, got.slammable);
				return;
			end
			want = marks_due.pop_front();
			if (got.cell_x !== want.cell_x || got.cell_y !== want.cell_y ||
					got.obstacle !== want.obstacle || got.slammable !== want.slammable) begin
				n_fail++;
				if (n_fail <= 10)
					$display("mark mismatch: exp (%0d,%0d) obs %0b slam %0b, got (%0d,%0d) obs %0b slam %0b",
						want.cell_x, want.cell_y, want.obstacle, want.slammable,
						got.cell_x, got.cell_y, got.obstacle, got.slammable);
			end
		endfunction

		function int pending();
			return marks_due.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        point_valid;
	logic        point_stall;
	lstc_pkg::lstc_point_t point;
	logic        mark_valid;
	logic        mark_stall;
	lstc_pkg::lstc_mark_t  mark;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lidar_slope_terrain_classifier_top #(
		.MAP_CELLS(MAP_CELLS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point      (point),
		.mark_valid (mark_valid),
		.mark_stall (mark_stall),
		.mark       (mark),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	mark_predictor sb;

	// idling knobs, percent of cycles; hold_req hands a long hold to the mark side
	int sender_idle_pct = 0;
	int rx_stall_pct    = 0;
	int hold_req        = 0;

	// ------------------------------------------------------------------------
	// Clock and run limit
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit: many times the slowest legal run of this stimulus
	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Mark side: check every accepted transaction, then pick next stall.
	// A pending hold request forces stall high for a counted stretch while
	// the point side keeps offering, so the output register and the
	// sequencer fill up and point_stall has to hold.
	// ------------------------------------------------------------------------
	initial begin : mark_side
		int hold_left;
		hold_left = 0;
		mark_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && mark_valid && !mark_stall)
				sb.check_mark(mark);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				mark_stall <= 1'b1;
				hold_left--;
			end else begin
				mark_stall <= ($urandom_range(0, 99) < rx_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Register port: setup cycle, access cycle, then a return to idle so that
	// back-to-back writes never assign psel twice in one step.
	// ------------------------------------------------------------------------
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_regs(input int obs, input int slam, input int minh, input int maxo,
			input int drp, input int ox, input int oy, input int cs);
		reg_write(lstc_pkg::REG_OBS_TAN2, obs);
		reg_write(lstc_pkg::REG_SLAM_TAN2, slam);
		reg_write(lstc_pkg::REG_MIN_HEIGHT, minh);
		reg_write(lstc_pkg::REG_MAX_OBS_H, maxo);
		reg_write(lstc_pkg::REG_DROP, drp);
		reg_write(lstc_pkg::REG_ORIGIN_X, ox);
		reg_write(lstc_pkg::REG_ORIGIN_Y, oy);
		reg_write(lstc_pkg::REG_CELL_SIZE, cs);
	endtask

	// ------------------------------------------------------------------------
	// Point side. Valid stays high from one transaction to the next unless
	// an idle gap is drawn, so only one NBA per signal per step.
	// ------------------------------------------------------------------------
	task automatic send_point(input lstc_pkg::lstc_point_t p);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			point_valid <= 1'b0;
			@(posedge clk);
		end
		point       <= p;
		point_valid <= 1'b1;
		do @(posedge clk); while (point_stall);
		sb.note_point(p);
	endtask

	function automatic lstc_pkg::lstc_point_t make_point(int x, int y, int z, int r, bit s);
		lstc_pkg::lstc_point_t p;
		p.x_mm        = x[19:0];
		p.y_mm        = y[19:0];
		p.z_mm        = z[19:0];
		p.range_mm    = r[17:0];
		p.slice_start = s;
		return p;
	endfunction

	function automatic longint clamp20(longint v);
		if (v > 524287)
			return 524287;
		if (v < -524288)
			return -524288;
		return v;
	endfunction

	function automatic longint rnd_sym(int m);
		return longint'($urandom_range(0, 2 * m)) - m;
	endfunction

	// raw noise: any bit pattern in every field
	function automatic lstc_pkg::lstc_point_t noise_point();
		lstc_pkg::lstc_point_t p;
		p.x_mm        = 20'($urandom);
		p.y_mm        = 20'($urandom);
		p.z_mm        = 20'($urandom);
		p.range_mm    = 18'($urandom);
		p.slice_start = 1'($urandom_range(0, 1));
		return p;
	endfunction

	// one slice walked across the grid of the current setting, mostly in
	// bounds, with a random mix of flat, steep, vertical, zero-length, drop
	// and rise pairs and a sprinkling of short-range and low points
	task automatic send_slice(input int len);
		longint      cs;
		longint      span;
		longint      x;
		longint      y;
		longint      z;
		int          sel;
		lstc_pkg::lstc_point_t p;
		cs   = (sb.cell_sz == 0) ? 1 : longint'(sb.cell_sz);
		span = cs * MAP_CELLS;
		x = longint'(sb.org_x) + longint'($urandom_range(0, int'(span + span / 8))) - span / 16;
		y = longint'(sb.org_y) + longint'($urandom_range(0, int'(span + span / 8))) - span / 16;
		z = longint'(sb.min_h) + longint'($urandom_range(0, 3000));
		for (int i = 0; i < len; i++) begin
			if (i > 0) begin
				sel = $urandom_range(0, 9);
				if (sel > 1) begin
					x += rnd_sym(150);
					y += rnd_sym(150);
				end
				case (sel)
					0:       z += rnd_sym(3000);                     // vertical
					1:       ;                                       // zero length
					2, 3, 4: z += rnd_sym(20);
					5, 6, 7: z += rnd_sym(300);
					8:       z -= longint'($urandom_range(100, 3000)); // drop
					default: z += longint'($urandom_range(100, 3000)); // rise
				endcase
				if ($urandom_range(0, 19) == 0)
					z = longint'(sb.min_h) - longint'($urandom_range(1, 50));
			end
			x = clamp20(x);
			y = clamp20(y);
			z = clamp20(z);
			p.x_mm     = x[19:0];
			p.y_mm     = y[19:0];
			p.z_mm     = z[19:0];
			p.range_mm = ($urandom_range(0, 19) == 0) ? 18'($urandom_range(0, 200))
				: 18'($urandom_range(201, 262143));
			p.slice_start = (i == 0);
			send_point(p);
		end
	endtask

	task automatic run_random(input int n);
		int cnt;
		int len;
		cnt = 0;
		while (cnt < n) begin
			if ($urandom_range(0, 99) < 15) begin
				send_point(noise_point());
				cnt++;
			end else begin
				len = $urandom_range(2, 12);
				send_slice(len);
				cnt += len;
			end
		end
		point_valid <= 1'b0;
	endtask

	// all marks in, then let any point still in flight finish
	task automatic wait_idle();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Directed points under reset register values (cell 50 mm, origin 0,
	// min height -500, max obstacle height 1500, drop 100)
	// ------------------------------------------------------------------------
	task automatic run_directed();
		send_point(make_point(100, 100, 0, 1000, 0));        // no previous point yet
		send_point(make_point(150, 100, 0, 1000, 0));        // flat pair
		send_point(make_point(160, 100, 100, 1000, 0));      // steep, below max height
		send_point(make_point(160, 100, 300, 1000, 0));      // vertical pair
		send_point(make_point(160, 100, 300, 1000, 0));      // zero-length pair
		send_point(make_point(1160, 100, 100, 1000, 0));     // shallow but big drop
		send_point(make_point(1170, 100, 2000, 1000, 0));    // steep above max height
		send_point(make_point(1180, 100, 2000, 200, 0));     // later range at null
		send_point(make_point(1190, 100, 2000, 201, 0));     // earlier range at null
		send_point(make_point(1200, 100, 1990, 201, 0));     // both just above null
		send_point(make_point(1210, 100, -501, 5000, 0));    // below min height
		send_point(make_point(1220, 100, -500, 5000, 0));    // at min height
		send_point(make_point(-10, 100, -500, 5000, 0));     // earlier in grid
		send_point(make_point(0, 100, -500, 5000, 0));       // earlier left of grid
		send_point(make_point(51199, 51199, -500, 5000, 0)); // earlier at x cell 0
		send_point(make_point(51200, 51199, -500, 5000, 0)); // earlier at last cell
		send_point(make_point(100, 51200, -500, 5000, 0));   // earlier past grid in x
		send_point(make_point(100, 100, -500, 5000, 0));     // earlier past grid in y
		send_point(make_point(200, 200, -500, 5000, 1));     // new slice
		send_point(make_point(200, 201, 524287, 262143, 0)); // largest rise
		send_point(make_point(200, 200, -500, 262143, 0));   // largest drop
		send_point(make_point(-524288, -524288, -524288, 0, 0));
		send_point(make_point(524287, 524287, 524287, 262143, 1));
		point_valid <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		sb = new();
		arst_n      <= 1'b0;
		point_valid <= 1'b0;
		point       <= '0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, no idling
		run_directed();
		run_random(ITEMS_PER_RUN);
		wait_idle();

		// extremes: grid spans nearly all of x/y, nothing low, any change in z is steep
		load_regs(0, 24'hFFFFFF, -524288, 524287, 0, -524288, -524288, 1023);
		sender_idle_pct = 84;
		run_random(ITEMS_PER_RUN);
		wait_idle();

		// opposite extremes, zero cell size acts as 1 mm
		sender_idle_pct = 0;
		rx_stall_pct    = 84;
		load_regs(24'hFFFFFF, 0, 0, -524288, 65535, 1000, -1000, 0);
		run_random(ITEMS_PER_RUN);
		wait_idle();

		// mid values, 1 mm cells
		sender_idle_pct = 23;
		rx_stall_pct    = 23;
		load_regs(200000, 1000, -3000, -1500, 40, -20000, 30000, 1);
		run_random(ITEMS_PER_RUN);
		wait_idle();

		// back to reset values; long hold on the mark side to back up the block
		sender_idle_pct = 0;
		rx_stall_pct    = 0;
		load_regs(lstc_pkg::OBS_TAN2_RST, lstc_pkg::SLAM_TAN2_RST, lstc_pkg::MIN_HEIGHT_RST,
			lstc_pkg::MAX_OBS_H_RST, lstc_pkg::DROP_RST, 0, 0, lstc_pkg::CELL_SIZE_RST);
		hold_req = HOLD_CYCLES;
		run_random(ITEMS_PER_RUN);
		wait_idle();

		if (sb.n_fail == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/lstc_pkg.sv
sv/lidar_slope_terrain_classifier_top.sv
dv/tb_lidar_slope_terrain_classifier_top.sv
